[design/one_bit_gradient_quantizer_assert.svh]
// -----------------------------------------------------------------------------
// one_bit_gradient_quantizer_assert.svh
// assertion macros shared by the quantizer checkers
// -----------------------------------------------------------------------------
`ifndef ONE_BIT_GRADIENT_QUANTIZER_ASSERT_SVH
`define ONE_BIT_GRADIENT_QUANTIZER_ASSERT_SVH

// property checked outside reset only
`define OBGQ_ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define OBGQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/obgq_pkg.sv]
// -----------------------------------------------------------------------------
// obgq_pkg
// shared widths, codes and the request record of the one-bit quantizer
// -----------------------------------------------------------------------------
package obgq_pkg;

  localparam int unsigned ELEMENTS_DEF = 1024;
  localparam int unsigned WORKERS_DEF  = 4;

  localparam int OP_W     = 2;
  localparam int WORKER_W = 2;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 16;
  localparam int STEP_W   = 2;
  localparam int RATE_W   = 32;

  localparam logic [RATE_W-1:0] RATE_RESET = 32'd655;

  // request queue depth, power of two
  localparam int QUEUE_DEPTH = 2;

  // request op codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUANT = 2'd1;
  localparam logic [OP_W-1:0] OP_APPLY = 2'd2;

  // request class decided by the front end
  typedef enum logic [2:0] {
    KIND_SKIP  = 3'd0,  // element out of range, all-zero result
    KIND_LOAD  = 3'd1,  // threshold load
    KIND_QUANT = 3'd2,  // gradient quantize
    KIND_APPLY = 3'd3,  // weight apply
    KIND_PASS  = 3'd4   // no state change, report counter
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [WORKER_W-1:0]        worker;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
  } item_t;

endpackage

[design/obgq_front.sv]
// -----------------------------------------------------------------------------
// obgq_front
// request intake: handshake and classification into the queue
// -----------------------------------------------------------------------------
module obgq_front #(
  parameter int unsigned ELEMENTS = obgq_pkg::ELEMENTS_DEF,
  parameter int unsigned WORKERS  = obgq_pkg::WORKERS_DEF
) (
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [obgq_pkg::OP_W-1:0]             in_op,
  input  logic [obgq_pkg::WORKER_W-1:0]         in_worker,
  input  logic [obgq_pkg::INDEX_W-1:0]          in_index,
  input  logic signed [obgq_pkg::VALUE_W-1:0]   in_value,
  input  logic                                  q_full,
  input  logic                                  clearing,
  output logic                                  busy,
  output logic                                  push,
  output obgq_pkg::item_t                       item
);
  import obgq_pkg::*;

  kind_t kind;

  always_comb begin
    kind = KIND_SKIP;
    if (32'(in_index) < ELEMENTS) begin
      case (in_op)
        OP_LOAD:  kind = KIND_LOAD;
        OP_QUANT: kind = (32'(in_worker) < WORKERS) ? KIND_QUANT : KIND_PASS;
        OP_APPLY: kind = KIND_APPLY;
        default:  kind = KIND_PASS;
      endcase
    end
  end

  assign busy = !rst_n || clearing || q_full;
  assign push = start && !busy;

  assign item.kind   = kind;
  assign item.worker = in_worker;
  assign item.index  = in_index;
  assign item.value  = in_value;

endmodule

[design/obgq_queue.sv]
// -----------------------------------------------------------------------------
// obgq_queue
// short request queue between front end and back end
// -----------------------------------------------------------------------------
module obgq_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  obgq_pkg::item_t  push_item,
  input  logic             pop,
  output obgq_pkg::item_t  head,
  output logic             empty,
  output logic             full
);
  import obgq_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = CW'(count_r + 1'b1);
      2'b01:   count_nxt = CW'(count_r - 1'b1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/obgq_back.sv]
// -----------------------------------------------------------------------------
// obgq_back
// execution sequencer: element and residual stores, quantize and apply math
// -----------------------------------------------------------------------------
module obgq_back #(
  parameter int unsigned ELEMENTS = obgq_pkg::ELEMENTS_DEF,
  parameter int unsigned WORKERS  = obgq_pkg::WORKERS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [obgq_pkg::RATE_W-1:0]           rate,
  input  obgq_pkg::item_t                       head,
  input  logic                                  q_empty,
  output logic                                  pop,
  output logic                                  clearing,
  output logic                                  out_strobe,
  output logic signed [obgq_pkg::STEP_W-1:0]    out_step,
  output logic signed [obgq_pkg::VALUE_W-1:0]   out_new_weight,
  output logic signed [obgq_pkg::COUNT_W-1:0]   out_count_now
);
  import obgq_pkg::*;

  localparam int unsigned RDEPTH = WORKERS * ELEMENTS;
  localparam int EW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int RW = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  localparam logic signed [STEP_W-1:0] STEP_ZERO = 2'sb00;
  localparam logic signed [STEP_W-1:0] STEP_POS  = 2'sb01;
  localparam logic signed [STEP_W-1:0] STEP_NEG  = 2'sb11;

  typedef enum logic [9:0] {
    ST_CLEAR   = 10'b0000000001,
    ST_IDLE    = 10'b0000000010,
    ST_DATA    = 10'b0000000100,
    ST_QEX     = 10'b0000001000,
    ST_QCOMMIT = 10'b0000010000,
    ST_ABS     = 10'b0000100000,
    ST_MULH    = 10'b0001000000,
    ST_MULL    = 10'b0010000000,
    ST_CLAMP   = 10'b0100000000,
    ST_APPLY   = 10'b1000000000
  } state_t;

  function automatic logic signed [VALUE_W-1:0] sat_word(input logic signed [35:0] v);
    logic signed [VALUE_W-1:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[VALUE_W-1:0];
    end
    return r;
  endfunction

  // stores, reset by the clearing sweep
  logic signed [VALUE_W-1:0] thr_mem [ELEMENTS];
  logic signed [COUNT_W-1:0] cnt_mem [ELEMENTS];
  logic signed [VALUE_W-1:0] srs_mem [RDEPTH];
  logic signed [VALUE_W-1:0] lrs_mem [RDEPTH];

  state_t                     state_r, state_nxt;
  logic [RW-1:0]              clr_addr_r, clr_addr_nxt;

  item_t                      item_r;
  logic [EW-1:0]              e_addr_r;
  logic [RW-1:0]              r_addr_r;
  logic [EW-1:0]              rd_e_addr;
  logic [RW-1:0]              rd_r_addr;

  logic signed [VALUE_W-1:0]  thr_rd_r, srs_rd_r, lrs_rd_r;
  logic signed [COUNT_W-1:0]  cnt_rd_r;

  logic signed [VALUE_W-1:0]  sum_r;
  logic                       neg_r, zero_r;
  logic signed [33:0]         ex_r;
  logic signed [47:0]         tc_r;
  logic [46:0]                m_r;
  logic [62:0]                ph_r, pl_r;
  logic signed [34:0]         d_r;

  logic signed [33:0]         sum_wide, mag;
  logic [63:0]                p_full;
  logic [33:0]                p_clamp;
  logic signed [COUNT_W-1:0]  cnt_step;

  logic                       thr_we, cnt_we, srs_we, lrs_we;
  logic [EW-1:0]              el_waddr;
  logic [RW-1:0]              rs_waddr;
  logic signed [VALUE_W-1:0]  thr_wdata, srs_wdata, lrs_wdata;
  logic signed [COUNT_W-1:0]  cnt_wdata;

  logic                       emit;
  logic signed [STEP_W-1:0]   emit_step;
  logic signed [VALUE_W-1:0]  emit_weight;
  logic signed [COUNT_W-1:0]  emit_count;

  logic                       strobe_r;
  logic signed [STEP_W-1:0]   step_r;
  logic signed [VALUE_W-1:0]  weight_r;
  logic signed [COUNT_W-1:0]  count_r;

  assign rd_e_addr = EW'(head.index);
  assign rd_r_addr = RW'(RW'(head.worker) * RW'(ELEMENTS) + RW'(head.index));
  assign clearing  = (state_r == ST_CLEAR);

  assign sum_wide = 34'(item_r.value) + 34'(srs_rd_r) + 34'(lrs_rd_r);
  assign mag      = sum_r[VALUE_W-1] ? -34'(sum_r) : 34'(sum_r);
  assign p_full   = 64'(ph_r) + 64'(pl_r >> 16);
  assign p_clamp  = (p_full > (64'd1 << 33)) ? (34'd1 << 33) : p_full[33:0];
  assign cnt_step = neg_r
                  ? ((cnt_rd_r == -16'sd32768) ? cnt_rd_r : cnt_rd_r - 16'sd1)
                  : ((cnt_rd_r == 16'sd32767) ? cnt_rd_r : cnt_rd_r + 16'sd1);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    pop          = 1'b0;
    thr_we       = 1'b0;
    cnt_we       = 1'b0;
    srs_we       = 1'b0;
    lrs_we       = 1'b0;
    el_waddr     = e_addr_r;
    rs_waddr     = r_addr_r;
    thr_wdata    = '0;
    cnt_wdata    = '0;
    srs_wdata    = '0;
    lrs_wdata    = '0;
    emit         = 1'b0;
    emit_step    = STEP_ZERO;
    emit_weight  = '0;
    emit_count   = '0;
    case (state_r)
      ST_CLEAR: begin
        srs_we   = 1'b1;
        lrs_we   = 1'b1;
        rs_waddr = clr_addr_r;
        el_waddr = EW'(clr_addr_r);
        thr_we   = (32'(clr_addr_r) < ELEMENTS);
        cnt_we   = (32'(clr_addr_r) < ELEMENTS);
        if (clr_addr_r == RW'(RDEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = RW'(clr_addr_r + 1'b1);
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        case (item_r.kind)
          KIND_QUANT: state_nxt = ST_QEX;
          KIND_APPLY: state_nxt = ST_ABS;
          KIND_LOAD: begin
            thr_we     = 1'b1;
            thr_wdata  = item_r.value;
            emit       = 1'b1;
            emit_count = cnt_rd_r;
            state_nxt  = ST_IDLE;
          end
          KIND_PASS: begin
            emit       = 1'b1;
            emit_count = cnt_rd_r;
            state_nxt  = ST_IDLE;
          end
          default: begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_QEX: state_nxt = ST_QCOMMIT;
      ST_QCOMMIT: begin
        emit       = 1'b1;
        emit_count = cnt_rd_r;
        if (!zero_r) begin
          srs_we = 1'b1;
          lrs_we = 1'b1;
          if (!ex_r[33]) begin
            // at or above threshold: count a step, excess to long residual
            cnt_we     = 1'b1;
            cnt_wdata  = cnt_step;
            lrs_wdata  = sat_word(36'(neg_r ? -ex_r : ex_r));
            emit_step  = neg_r ? STEP_NEG : STEP_POS;
            emit_count = cnt_step;
          end else begin
            srs_wdata = sum_r;
          end
        end
        state_nxt = ST_IDLE;
      end
      ST_ABS:   state_nxt = ST_MULH;
      ST_MULH:  state_nxt = ST_MULL;
      ST_MULL:  state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_APPLY;
      ST_APPLY: begin
        emit        = 1'b1;
        emit_weight = sat_word(36'(item_r.value) + 36'(d_r));
        emit_count  = cnt_rd_r;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      strobe_r   <= emit;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r   <= head;
      e_addr_r <= rd_e_addr;
      r_addr_r <= rd_r_addr;
    end
    if (state_r == ST_DATA) begin
      sum_r <= sat_word(36'(sum_wide));
      tc_r  <= 48'(thr_rd_r) * 48'(cnt_rd_r);
    end
    if (state_r == ST_QEX) begin
      ex_r   <= mag - 34'(thr_rd_r);
      neg_r  <= sum_r[VALUE_W-1];
      zero_r <= (sum_r == '0);
    end
    if (state_r == ST_ABS) begin
      neg_r <= tc_r[47];
      m_r   <= 47'(tc_r[47] ? -tc_r : tc_r);
    end
    if (state_r == ST_MULH) begin
      ph_r <= 63'(m_r) * 63'(rate[31:16]);
    end
    if (state_r == ST_MULL) begin
      pl_r <= 63'(m_r) * 63'(rate[15:0]);
    end
    if (state_r == ST_CLAMP) begin
      d_r <= neg_r ? -$signed(35'(p_clamp)) : $signed(35'(p_clamp));
    end
    if (emit) begin
      step_r   <= emit_step;
      weight_r <= emit_weight;
      count_r  <= emit_count;
    end
  end

  always_ff @(posedge clk) begin
    if (thr_we) begin
      thr_mem[el_waddr] <= thr_wdata;
    end
    if (pop) begin
      thr_rd_r <= thr_mem[rd_e_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[el_waddr] <= cnt_wdata;
    end
    if (pop) begin
      cnt_rd_r <= cnt_mem[rd_e_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (srs_we) begin
      srs_mem[rs_waddr] <= srs_wdata;
    end
    if (pop) begin
      srs_rd_r <= srs_mem[rd_r_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lrs_we) begin
      lrs_mem[rs_waddr] <= lrs_wdata;
    end
    if (pop) begin
      lrs_rd_r <= lrs_mem[rd_r_addr];
    end
  end

  assign out_strobe     = strobe_r;
  assign out_step       = step_r;
  assign out_new_weight = weight_r;
  assign out_count_now  = count_r;

endmodule

[design/one_bit_gradient_quantizer.sv]
// -----------------------------------------------------------------------------
// one_bit_gradient_quantizer
// one-bit gradient quantizer with error feedback, Q16.16 saturating
// -----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low; exactly
// one result follows for every request, in request order, as a one-cycle
// pulse on out_strobe with out_step, out_new_weight and out_count_now valid
// in that cycle. There is no way to hold results off, so capture them when
// the strobe is seen. After reset busy stays high for a clearing sweep over
// all WORKERS*ELEMENTS residual addresses that zeroes every threshold,
// counter and residual, one residual address a cycle. After that the back
// end runs one request at a time and pops no new request before it has
// finished the last one. The execution sequencer reads all four stores
// together as it pops a request, then walks the quantize add/compare steps
// or the multiplier steps of the apply path (32x16 product, then two 47x16
// partial products); a threshold load, an unused op code or an out-of-range
// element ends once the stores are read. A two-entry request queue sits in
// front, so start is taken while the back end works and busy otherwise
// rises only during reset or when the queue is full. The step rate register
// is written through cfg_we/cfg_wdata at any edge but should only change
// while no request is outstanding.
// -----------------------------------------------------------------------------
module one_bit_gradient_quantizer #(
  parameter int unsigned ELEMENTS = obgq_pkg::ELEMENTS_DEF,
  parameter int unsigned WORKERS  = obgq_pkg::WORKERS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic [obgq_pkg::OP_W-1:0]             in_op,
  input  logic [obgq_pkg::WORKER_W-1:0]         in_worker,
  input  logic [obgq_pkg::INDEX_W-1:0]          in_index,
  input  logic signed [obgq_pkg::VALUE_W-1:0]   in_value,
  // result channel
  output logic                                  out_strobe,
  output logic signed [obgq_pkg::STEP_W-1:0]    out_step,
  output logic signed [obgq_pkg::VALUE_W-1:0]   out_new_weight,
  output logic signed [obgq_pkg::COUNT_W-1:0]   out_count_now,
  // learning rate register
  input  logic                                  cfg_we,
  input  logic [obgq_pkg::RATE_W-1:0]           cfg_wdata
);
  import obgq_pkg::*;

  logic [RATE_W-1:0]  rate_r;

  logic               push;
  item_t              push_item;
  item_t              head;
  logic               q_empty;
  logic               q_full;
  logic               pop;
  logic               clearing;

  // learning rate, unsigned Q16.16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
    end
  end

  // intake: handshake and range classification
  obgq_front #(
    .ELEMENTS (ELEMENTS),
    .WORKERS  (WORKERS)
  ) u_front (
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .in_worker (in_worker),
    .in_index  (in_index),
    .in_value  (in_value),
    .q_full    (q_full),
    .clearing  (clearing),
    .busy      (busy),
    .push      (push),
    .item      (push_item)
  );

  // decouples intake from execution
  obgq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // stores and arithmetic, one request at a time
  obgq_back #(
    .ELEMENTS (ELEMENTS),
    .WORKERS  (WORKERS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rate           (rate_r),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .clearing       (clearing),
    .out_strobe     (out_strobe),
    .out_step       (out_step),
    .out_new_weight (out_new_weight),
    .out_count_now  (out_count_now)
  );

endmodule

[design/obgq_checker.sv]
// -----------------------------------------------------------------------------
// obgq_checker
// port-level checks of the quantizer, bound to the top level
// -----------------------------------------------------------------------------
`include "one_bit_gradient_quantizer_assert.svh"

module obgq_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  busy,
  input  logic                                  out_strobe,
  input  logic signed [obgq_pkg::STEP_W-1:0]    out_step,
  input  logic signed [obgq_pkg::VALUE_W-1:0]   out_new_weight
);
  import obgq_pkg::*;

  // no request is taken during reset
  `OBGQ_ASSERT_ALWAYS(a_busy_in_reset, clk, !rst_n |-> busy, "busy low during reset")

  // reset kills any pending result pulse
  `OBGQ_ASSERT_ALWAYS(a_no_result_after_reset, clk, !rst_n |=> !out_strobe, "result right after reset")

  // result strobes never come back to back
  `OBGQ_ASSERT_RUN(a_strobe_single, clk, rst_n, out_strobe |=> !out_strobe, "back-to-back results")

  // a quantize step never comes with a weight
  `OBGQ_ASSERT_RUN(a_step_no_weight, clk, rst_n, out_strobe && out_step != 2'sd0 |-> out_new_weight == 32'sd0, "step with weight")

endmodule

bind one_bit_gradient_quantizer obgq_checker u_obgq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_step       (out_step),
  .out_new_weight (out_new_weight)
);

[tb/sv/obgq_result_checker.sv]
// ----------------------------------------------------------------------------
// obgq_result_checker
// Watches the request and result channels of the one-bit gradient quantizer,
// predicts every result from its own copy of the thresholds, sign counters,
// residuals and learning rate, and compares the results in request order.
// ----------------------------------------------------------------------------
module obgq_result_checker #(
  parameter int ELEMENTS = obgq_pkg::ELEMENTS_DEF,
  parameter int WORKERS  = obgq_pkg::WORKERS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [obgq_pkg::OP_W-1:0]            in_op,
  input  logic [obgq_pkg::WORKER_W-1:0]        in_worker,
  input  logic [obgq_pkg::INDEX_W-1:0]         in_index,
  input  logic signed [obgq_pkg::VALUE_W-1:0]  in_value,
  input  logic                                 out_strobe,
  input  logic signed [obgq_pkg::STEP_W-1:0]   out_step,
  input  logic signed [obgq_pkg::VALUE_W-1:0]  out_new_weight,
  input  logic signed [obgq_pkg::COUNT_W-1:0]  out_count_now,
  input  logic                                 cfg_we,
  input  logic [obgq_pkg::RATE_W-1:0]          cfg_wdata,
  output int                                   fail_count,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import obgq_pkg::*;

  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam longint MAX16 = 64'sd32767;
  localparam longint MIN16 = -64'sd32768;
  localparam longint unsigned PRODUCT_CAP = 64'd1 << 33;

  typedef struct {
    logic signed [STEP_W-1:0]  step;
    logic signed [VALUE_W-1:0] weight;
    logic signed [COUNT_W-1:0] count;
  } quant_result_t;

  logic signed [VALUE_W-1:0] threshold_mem [ELEMENTS];
  logic signed [COUNT_W-1:0] counter_mem   [ELEMENTS];
  logic signed [VALUE_W-1:0] short_mem     [WORKERS*ELEMENTS];
  logic signed [VALUE_W-1:0] long_mem      [WORKERS*ELEMENTS];
  logic [RATE_W-1:0]         rate;
  quant_result_t             expected_results [$];

  function automatic longint clamp32(input longint v);
    if (v > MAX32) return MAX32;
    if (v < MIN32) return MIN32;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] quantizer check: %s", $realtime, msg);
    fail_count++;
  endtask

  // update the model state for one request and queue its result
  task automatic predict_request(input logic [OP_W-1:0] op, input logic [WORKER_W-1:0] wk,
                                 input logic [INDEX_W-1:0] idx,
                                 input logic signed [VALUE_W-1:0] val);
    quant_result_t     r;
    int                slot;
    longint            thr, sum, mag, sgn, c, ex, tc, d, nw;
    longint unsigned   m, p, rh, rl;
    r.step   = '0;
    r.weight = '0;
    r.count  = '0;
    // element out of range: nothing changes, all-zero result
    if (int'(idx) < ELEMENTS) begin
      thr  = longint'(threshold_mem[idx]);
      slot = int'(wk) * ELEMENTS + int'(idx);
      case (op)
        OP_LOAD: begin
          threshold_mem[idx] = val;
        end
        OP_QUANT: begin
          // worker out of range leaves everything alone
          if (int'(wk) < WORKERS) begin
            sum = clamp32(longint'(val) + longint'(short_mem[slot]) +
                          longint'(long_mem[slot]));
            if (sum != 0) begin
              mag = (sum < 0) ? -sum : sum;
              sgn = (sum < 0) ? -64'sd1 : 64'sd1;
              if (mag >= thr) begin
                c = longint'(counter_mem[idx]) + sgn;
                if (c > MAX16) c = MAX16;
                if (c < MIN16) c = MIN16;
                counter_mem[idx] = c[COUNT_W-1:0];
                ex = mag - thr;
                long_mem[slot]  = VALUE_W'(clamp32(sgn * ex));
                short_mem[slot] = '0;
                r.step = sgn[STEP_W-1:0];
              end else begin
                short_mem[slot] = sum[VALUE_W-1:0];
                long_mem[slot]  = '0;
              end
            end
          end
        end
        OP_APPLY: begin
          tc = thr * longint'(counter_mem[idx]);
          m  = (tc < 0) ? -tc : tc;
          rh = 64'(rate[31:16]);
          rl = 64'(rate[15:0]);
          p  = m * rh + ((m * rl) >> 16);
          if (p > PRODUCT_CAP) p = PRODUCT_CAP;
          d  = (tc < 0) ? -longint'(p) : longint'(p);
          nw = clamp32(longint'(val) + d);
          r.weight = nw[VALUE_W-1:0];
        end
        default: begin
        end
      endcase
      r.count = counter_mem[idx];
    end
    expected_results.push_back(r);
  endtask

  task automatic check_result();
    quant_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result strobe with no request outstanding");
    end else begin
      want = expected_results.pop_front();
      if (out_step !== want.step)
        report_mismatch($sformatf("step got %0d want %0d", out_step, want.step));
      if (out_new_weight !== want.weight)
        report_mismatch($sformatf("new_weight got %h want %h", out_new_weight, want.weight));
      if (out_count_now !== want.count)
        report_mismatch($sformatf("count_now got %0d want %0d", out_count_now, want.count));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ELEMENTS; i++) begin
        threshold_mem[i] = '0;
        counter_mem[i]   = '0;
      end
      for (int i = 0; i < WORKERS*ELEMENTS; i++) begin
        short_mem[i] = '0;
        long_mem[i]  = '0;
      end
      rate = RATE_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) rate = cfg_wdata;
      // a result always belongs to an earlier request, so check before predicting
      if (out_strobe) check_result();
      if (start && !busy) predict_request(in_op, in_worker, in_index, in_value);
    end
    pending = expected_results.size();
  end

endmodule

[tb/sv/tb_one_bit_gradient_quantizer.sv]
// ----------------------------------------------------------------------------
// tb_one_bit_gradient_quantizer
// Drives requests into the one-bit gradient quantizer: a directed block of
// corner cases, long runs that walk two sign counters far from zero, then
// random load/quantize/apply sequences under several learning rates with
// random sender gaps. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_one_bit_gradient_quantizer;
  timeunit 1ns;
  timeprecision 1ps;
  import obgq_pkg::*;

  // spare op code, the block must leave its state alone
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // clearing sweep plus about 1900 requests with their longest sender gaps,
  // taken several times over
  localparam int CYCLE_LIMIT = 200_000;
  localparam int COUNT_RUN = 200;
  localparam int PHASE_ITEMS = 370;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [OP_W-1:0]           in_op = '0;
  logic [WORKER_W-1:0]       in_worker = '0;
  logic [INDEX_W-1:0]        in_index = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_strobe;
  logic signed [STEP_W-1:0]  out_step;
  logic signed [VALUE_W-1:0] out_new_weight;
  logic signed [COUNT_W-1:0] out_count_now;
  logic                      cfg_we = 1'b0;
  logic [RATE_W-1:0]         cfg_wdata = '0;

  int fail_count;
  int pending;
  int item_count = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  always #5 clk = ~clk;

  one_bit_gradient_quantizer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_worker      (in_worker),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_step       (out_step),
    .out_new_weight (out_new_weight),
    .out_count_now  (out_count_now),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  obgq_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_worker      (in_worker),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_step       (out_step),
    .out_new_weight (out_new_weight),
    .out_count_now  (out_count_now),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** one_bit_gradient_quantizer: FAILED **");
      $finish;
    end
  end

  // called at a falling edge; holds the request until an edge with busy low
  // and returns at the falling edge after acceptance, start still high
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [WORKER_W-1:0] wk,
                               input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
    start     <= 1'b1;
    in_op     <= op;
    in_worker <= wk;
    in_index  <= idx;
    in_value  <= val;
    do @(posedge clk); while (busy);
    item_count++;
    @(negedge clk);
  endtask

  // random sender gap, only while gaps are on
  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // drain every outstanding request, let the pipe settle, then write the rate
  task automatic set_rate_when_idle(input logic [RATE_W-1:0] r);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // gradients mostly near typical thresholds, with extremes and full-range noise
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0001;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] random_threshold();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return $urandom() | 32'h8000_0000;   // negative threshold
      2: return 32'h7FFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  // mostly a small working set so state builds up, sometimes anywhere
  function automatic logic [INDEX_W-1:0] random_index();
    case ($urandom_range(0, 9))
      8: return INDEX_W'($urandom());
      9: return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
      default: return INDEX_W'($urandom_range(0, 15));
    endcase
  endfunction

  // well-formed sequence: optional threshold load, a few gradients, a weight apply
  task automatic run_sequence();
    logic [INDEX_W-1:0] idx;
    int                 n;
    idx = random_index();
    n   = $urandom_range(2, 8);
    if ($urandom_range(0, 2) == 0) begin
      sender_gap();
      issue_request(OP_LOAD, WORKER_W'($urandom()), idx, random_threshold());
    end
    repeat (n) begin
      sender_gap();
      issue_request(OP_QUANT, WORKER_W'($urandom()), idx, random_value());
    end
    sender_gap();
    issue_request(OP_APPLY, WORKER_W'($urandom()), idx, random_value());
  endtask

  task automatic run_random_phase(input int count, input bit idle_allowed);
    int goal;
    goal    = item_count + count;
    gaps_on = idle_allowed;
    while (item_count < goal) begin
      // switch between gappy stretches and back-to-back stretches
      if ($urandom_range(0, 15) == 0) gaps_on = idle_allowed && ($urandom_range(0, 1) != 0);
      if ($urandom_range(0, 6) == 0) begin
        // noise request, any op including the spare code
        sender_gap();
        issue_request(OP_W'($urandom()), WORKER_W'($urandom()), random_index(), $urandom());
      end else begin
        run_sequence();
      end
    end
  endtask

  initial begin
    // synchronous reset, held low at the start
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // rate of 1.0 while the clearing sweep runs
    set_rate_when_idle(32'h0001_0000);

    // directed corner cases
    gaps_on = 1'b0;
    issue_request(OP_LOAD,  2'd0, 10'd0,    32'h0001_0000);
    issue_request(OP_LOAD,  2'd0, 10'd1023, 32'h7FFF_FFFF);
    issue_request(OP_LOAD,  2'd0, 10'd5,    32'h8000_0000);   // negative threshold
    issue_request(OP_QUANT, 2'd0, 10'd0,    32'h0000_0000);   // zero sum, nothing moves
    issue_request(OP_QUANT, 2'd0, 10'd0,    32'h0002_0000);   // above threshold, step up
    issue_request(OP_QUANT, 2'd0, 10'd0,    32'hFFFF_8000);   // below threshold, kept short
    issue_request(OP_QUANT, 2'd0, 10'd0,    32'hFFFD_0000);   // negative step
    issue_request(OP_QUANT, 2'd3, 10'd5,    32'h8000_0000);   // excess saturates low
    issue_request(OP_QUANT, 2'd3, 10'd5,    32'h8000_0000);   // sum saturates low
    issue_request(OP_QUANT, 2'd2, 10'd5,    32'h0000_0001);
    issue_request(OP_QUANT, 2'd1, 10'd1023, 32'h7FFF_FFFF);   // magnitude equals threshold
    issue_request(OP_QUANT, 2'd1, 10'd1023, 32'h7FFF_FFFE);   // just below
    issue_request(OP_QUANT, 2'd1, 10'd1023, 32'h7FFF_FFFF);   // sum saturates high
    issue_request(OP_APPLY, 2'd0, 10'd0,    32'h7FFF_FFFF);
    issue_request(OP_APPLY, 2'd0, 10'd1023, 32'h7FFF_FFFF);   // weight saturates high
    issue_request(OP_APPLY, 2'd3, 10'd5,    32'h8000_0000);
    issue_request(OP_APPLY, 2'd0, 10'd1023, 32'h8000_0000);
    issue_request(OP_APPLY, 2'd1, 10'd0,    32'h1234_5678);
    issue_request(OP_UNUSED, 2'd3, 10'd1023, 32'hFFFF_FFFF);
    issue_request(OP_UNUSED, 2'd0, 10'd0,   32'h0000_0000);
    issue_request(OP_LOAD,  2'd2, 10'd1023, 32'h0000_0000);
    issue_request(OP_QUANT, 2'd2, 10'd1023, 32'h0000_0000);   // zero sum on zero threshold

    // walk two counters far from zero at the largest rate
    set_rate_when_idle(32'hFFFF_FFFF);
    issue_request(OP_LOAD, 2'd0, 10'd7, 32'h0000_0000);
    repeat (COUNT_RUN) issue_request(OP_QUANT, 2'd0, 10'd7, 32'h0000_0001);
    issue_request(OP_APPLY, 2'd0, 10'd7, 32'h0000_0000);
    issue_request(OP_LOAD, 2'd1, 10'd8, 32'h0000_0000);
    repeat (COUNT_RUN) issue_request(OP_QUANT, 2'd1, 10'd8, 32'hFFFF_FFFF);
    // huge threshold times a large counter hits the product cap
    issue_request(OP_LOAD,  2'd0, 10'd7, 32'h7FFF_FFFF);
    issue_request(OP_APPLY, 2'd0, 10'd7, 32'h8000_0000);
    issue_request(OP_APPLY, 2'd0, 10'd7, 32'h0000_0000);
    issue_request(OP_LOAD,  2'd1, 10'd8, 32'h8000_0000);
    issue_request(OP_APPLY, 2'd1, 10'd8, 32'h7FFF_FFFF);
    issue_request(OP_QUANT, 2'd1, 10'd8, 32'h8000_0000);      // counter steps down again

    // random part, a different rate per phase, the last one without gaps
    run_random_phase(PHASE_ITEMS, 1'b1);
    set_rate_when_idle(32'h0000_0000);
    run_random_phase(PHASE_ITEMS, 1'b1);
    set_rate_when_idle($urandom());
    run_random_phase(PHASE_ITEMS, 1'b1);
    set_rate_when_idle(RATE_RESET);
    run_random_phase(PHASE_ITEMS, 1'b0);

    // wait for every result, then keep watching for stray strobes
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("** one_bit_gradient_quantizer: PASSED **");
    end else begin
      $display("** one_bit_gradient_quantizer: FAILED **");
    end
    $finish;
  end

endmodule
